// ----- rtl/core/ntc_pkg.sv -----
// shared constants, types and resistance table for the ntc adc to temperature core
// no dependencies; used by ntc_divider and ntc_adc_to_temperature_core

package ntc_pkg;

   localparam int ROM_SIZE              = 91;
   localparam int TABLE_ENTRIES_DEFAULT = 91;
   localparam int DIV_STEPS_DEFAULT     = 3;

   localparam int SAMPLE_W = 12;
   localparam int OFFSET_W = 8;
   localparam int TRIM_W   = 4;
   localparam int TEMP_W   = 7;
   localparam int A_W      = 13;
   localparam int NUM_W    = 26;
   localparam int DEN_W    = 13;
   localparam int QUOT_W   = 15;
   localparam int RES_W    = 16;
   localparam int SUM_W    = RES_W + 1;
   localparam int CMP_W    = DEN_W + QUOT_W;

   localparam logic [NUM_W-1:0] DIV_SCALE  = NUM_W'(10000);
   localparam logic [DEN_W-1:0] FULL_SCALE = DEN_W'(4096);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ADC_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM_ZERO  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM_ONE   = 2'd2;

   localparam logic [OFFSET_W-1:0] ADC_OFFSET_RESET = 8'd40;
   localparam logic [TRIM_W-1:0]   TRIM_ZERO_RESET  = 4'd3;
   localparam logic [TRIM_W-1:0]   TRIM_ONE_RESET   = 4'd0;

   // divider resistance in ohms, one entry per degree, descending
   localparam logic [RES_W-1:0] RES_ROM [ROM_SIZE] = '{
      16'd27494, 16'd26325, 16'd25212, 16'd24153, 16'd23144, 16'd22184, 16'd21268,
      16'd20396, 16'd19564, 16'd18771, 16'd18015, 16'd17294, 16'd16605, 16'd15948,
      16'd15320, 16'd14720, 16'd14148, 16'd13600, 16'd13077, 16'd12577, 16'd12099,
      16'd11641, 16'd11204, 16'd10785, 16'd10384, 16'd10000, 16'd9632,  16'd9280,
      16'd8943,  16'd8620,  16'd8310,  16'd8012,  16'd7728,  16'd7454,  16'd7192,
      16'd6940,  16'd6699,  16'd6467,  16'd6244,  16'd6030,  16'd5825,  16'd5628,
      16'd5438,  16'd5256,  16'd5080,  16'd4912,  16'd4750,  16'd4594,  16'd4444,
      16'd4300,  16'd4161,  16'd4027,  16'd3898,  16'd3774,  16'd3654,  16'd3539,
      16'd3428,  16'd3322,  16'd3219,  16'd3119,  16'd3023,  16'd2931,  16'd2842,
      16'd2756,  16'd2673,  16'd2593,  16'd2517,  16'd2441,  16'd2369,  16'd2299,
      16'd2232,  16'd2167,  16'd2105,  16'd2044,  16'd1985,  16'd1929,  16'd1874,
      16'd1821,  16'd1770,  16'd1720,  16'd1673,  16'd1626,  16'd1581,  16'd1538,
      16'd1496,  16'd1455,  16'd1416,  16'd1378,  16'd1341,  16'd1305,  16'd1270
   };

   typedef struct packed {
      logic              fault;
      logic [TRIM_W-1:0] trim;
   } side_type;

endpackage

// ----- rtl/core/ntc_adc_to_temperature_core.sv -----
// ntc thermistor adc sample to whole-degree temperature, fully pipelined
// depends on ntc_pkg and ntc_divider
//
// usage:
//   req channel: req_valid / req_stall with req_adc_sample and req_channel_sel.
//   rsp channel: rsp_valid / rsp_stall with rsp_temperature and rsp_sensor_fault.
//   csr port: csr_write with csr_index and csr_data; index 0 adc offset,
//   1 trim for channel zero, 2 trim for channel one, other indexes ignored.
//   write csr only while no word is in flight.
// path: stages 1 to 3, the divider stages, the table compare stage and the output
//   register; the divider resolves three quotient bits per stage by default.
// throughput: one word per cycle while rsp_stall is low; the quotient pipeline sets
//   the depth and every stage hands its word on whenever the stage after it is ready.
// reset: pipeline empties, csr registers return to offset 40, trims 3 and 0.
// stall: a stalled rsp word holds; upstream stages keep filling empty
//   stages, and req_stall rises once every stage holds a word.

module ntc_adc_to_temperature_core #(
   parameter int TABLE_ENTRIES = ntc_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int DIV_STEPS     = ntc_pkg::DIV_STEPS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [ntc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ntc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ntc_pkg::SAMPLE_W-1:0]       req_adc_sample,
   input  logic                               req_channel_sel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ntc_pkg::TEMP_W-1:0]         rsp_temperature,
   output logic                               rsp_sensor_fault
);

   localparam int USED = (TABLE_ENTRIES > ntc_pkg::ROM_SIZE) ? ntc_pkg::ROM_SIZE :
                         (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
   localparam int GE_W = USED - 1;
   localparam logic [ntc_pkg::RES_W-1:0] RES_FIRST = ntc_pkg::RES_ROM[0];
   localparam logic [ntc_pkg::RES_W-1:0] RES_LAST  = ntc_pkg::RES_ROM[USED-1];

   // csr registers
   logic [ntc_pkg::OFFSET_W-1:0] offset_ff;
   logic [ntc_pkg::TRIM_W-1:0]   trim0_ff;
   logic [ntc_pkg::TRIM_W-1:0]   trim1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= ntc_pkg::ADC_OFFSET_RESET;
         trim0_ff  <= ntc_pkg::TRIM_ZERO_RESET;
         trim1_ff  <= ntc_pkg::TRIM_ONE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ntc_pkg::CSR_ADC_OFFSET: offset_ff <= csr_data;
            ntc_pkg::CSR_TRIM_ZERO:  trim0_ff  <= csr_data[ntc_pkg::TRIM_W-1:0];
            ntc_pkg::CSR_TRIM_ONE:   trim1_ff  <= csr_data[ntc_pkg::TRIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage ready chain
   logic rsp_rdy, s9_rdy, div_in_ready, s3_rdy, s2_rdy, s1_rdy;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s9_v_ff, rsp_valid_ff;

   assign rsp_rdy   = !rsp_valid_ff || !rsp_stall;
   assign s9_rdy    = !s9_v_ff || rsp_rdy;
   assign s3_rdy    = !s3_v_ff || div_in_ready;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   assign s1_rdy    = !s1_v_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   // stage 1: offset sample
   logic [ntc_pkg::A_W-1:0]    s1_a_ff, s1_a_in;
   logic [ntc_pkg::TRIM_W-1:0] s1_trim_ff, s1_trim_in;

   assign s1_a_in    = ntc_pkg::A_W'(req_adc_sample) + ntc_pkg::A_W'(offset_ff);
   assign s1_trim_in = req_channel_sel ? trim1_ff : trim0_ff;

   // stage 2: numerator and denominator
   logic [ntc_pkg::NUM_W-1:0] s2_num_ff, s2_num_in;
   logic [ntc_pkg::DEN_W-1:0] s2_den_ff, s2_den_in;
   ntc_pkg::side_type         s2_side_ff, s2_side_in;

   assign s2_num_in        = ntc_pkg::NUM_W'(s1_a_ff) * ntc_pkg::DIV_SCALE;
   assign s2_den_in        = ntc_pkg::FULL_SCALE - s1_a_ff;
   assign s2_side_in.fault = s1_a_ff[ntc_pkg::A_W-1];
   assign s2_side_in.trim  = s1_trim_ff;

   // stage 3: quotient range check
   logic [ntc_pkg::NUM_W-1:0] s3_num_ff;
   logic [ntc_pkg::DEN_W-1:0] s3_den_ff;
   ntc_pkg::side_type         s3_side_ff, s3_side_in;
   logic                      s3_ovf;

   assign s3_ovf = {{(ntc_pkg::CMP_W - ntc_pkg::NUM_W){1'b0}}, s2_num_ff}
                   >= {s2_den_ff, {ntc_pkg::QUOT_W{1'b0}}};
   assign s3_side_in.fault = s2_side_ff.fault || s3_ovf;
   assign s3_side_in.trim  = s2_side_ff.trim;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= req_valid;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_rdy) begin
            s3_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_valid) begin
         s1_a_ff    <= s1_a_in;
         s1_trim_ff <= s1_trim_in;
      end
      if (s2_rdy && s1_v_ff) begin
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_side_ff <= s2_side_in;
      end
      if (s3_rdy && s2_v_ff) begin
         s3_num_ff  <= s2_num_ff;
         s3_den_ff  <= s2_den_ff;
         s3_side_ff <= s3_side_in;
      end
   end

   // divider
   logic                       div_out_valid;
   logic [ntc_pkg::QUOT_W-1:0] div_quot;
   ntc_pkg::side_type          div_side;

   ntc_divider #(
      .STEPS_PER_STAGE (DIV_STEPS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (div_in_ready),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (div_out_valid),
      .out_ready (s9_rdy),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // table compare stage: bit i set when the word lies at or below the midpoint
   logic [GE_W-1:0]    s9_ge_ff, s9_ge_in;
   ntc_pkg::side_type  s9_side_ff, s9_side_in;
   logic [ntc_pkg::SUM_W-1:0] twice_r;

   assign twice_r = ntc_pkg::SUM_W'(div_quot) << 1;

   always_comb begin
      for (int i = 0; i < GE_W; i++) begin
         s9_ge_in[i] = twice_r <= (ntc_pkg::SUM_W'(ntc_pkg::RES_ROM[i])
                                   + ntc_pkg::SUM_W'(ntc_pkg::RES_ROM[i+1]));
      end
   end

   assign s9_side_in.fault = div_side.fault
                             || (ntc_pkg::RES_W'(div_quot) > RES_FIRST)
                             || (ntc_pkg::RES_W'(div_quot) < RES_LAST);
   assign s9_side_in.trim  = div_side.trim;

   // index encode and output word
   logic [ntc_pkg::TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic                       rsp_fault_ff;
   logic [GE_W:0]              ge_pad;
   logic [ntc_pkg::TEMP_W-1:0] idx;

   assign ge_pad = {1'b0, s9_ge_ff};

   always_comb begin
      idx = '0;
      for (int i = 0; i < GE_W; i++) begin
         if (ge_pad[i] && !ge_pad[i+1]) begin
            idx = idx | ntc_pkg::TEMP_W'(i + 1);
         end
      end
   end

   assign rsp_temp_in = s9_side_ff.fault ? '0 : idx + ntc_pkg::TEMP_W'(s9_side_ff.trim);

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s9_rdy) begin
            s9_v_ff <= div_out_valid;
         end
         if (rsp_rdy) begin
            rsp_valid_ff <= s9_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s9_rdy && div_out_valid) begin
         s9_ge_ff   <= s9_ge_in;
         s9_side_ff <= s9_side_in;
      end
      if (rsp_rdy && s9_v_ff) begin
         rsp_temp_ff  <= rsp_temp_in;
         rsp_fault_ff <= s9_side_ff.fault;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_temperature  = rsp_temp_ff;
   assign rsp_sensor_fault = rsp_fault_ff;

   // checks
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sensor_fault |-> rsp_temperature == '0)
      else $error("faulted word carries a nonzero temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sensor_fault
         |-> rsp_temperature <= ntc_pkg::TEMP_W'(USED - 1 + 15))
      else $error("temperature above table span plus trim");

   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      s9_v_ff && !s9_side_ff.fault |-> ((s9_ge_ff + GE_W'(1)) & s9_ge_ff) == '0)
      else $error("in-range word gives a broken midpoint compare vector");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_v_ff)
      else $error("accepted word missing from first stage");

endmodule

// ----- rtl/core/ntc_divider.sv -----
// pipelined restoring divider, a fixed number of quotient bits per stage
// depends on ntc_pkg for widths and the sideband word type

module ntc_divider #(
   parameter int STEPS_PER_STAGE = ntc_pkg::DIV_STEPS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ntc_pkg::NUM_W-1:0]      in_num,
   input  logic [ntc_pkg::DEN_W-1:0]      in_den,
   input  ntc_pkg::side_type              in_side,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [ntc_pkg::QUOT_W-1:0]     out_quot,
   output ntc_pkg::side_type              out_side
);

   localparam int STAGES = (ntc_pkg::QUOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int PAD_W  = ntc_pkg::CMP_W - ntc_pkg::NUM_W;

   logic                          v_ff    [STAGES];
   logic [ntc_pkg::NUM_W-1:0]     rem_ff  [STAGES];
   logic [ntc_pkg::QUOT_W-1:0]    quot_ff [STAGES];
   logic [ntc_pkg::DEN_W-1:0]     den_ff  [STAGES];
   ntc_pkg::side_type             side_ff [STAGES];
   logic [STAGES-1:0]             rdy;

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      localparam int K0 = ntc_pkg::QUOT_W - 1 - j * STEPS_PER_STAGE;

      logic                        v_src;
      logic [ntc_pkg::NUM_W-1:0]   rem_src;
      logic [ntc_pkg::QUOT_W-1:0]  quot_src;
      logic [ntc_pkg::DEN_W-1:0]   den_src;
      ntc_pkg::side_type           side_src;
      logic                        next_rdy;
      logic [ntc_pkg::NUM_W-1:0]   rem_in;
      logic [ntc_pkg::QUOT_W-1:0]  quot_in;

      if (j == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = in_num;
         assign quot_src = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = v_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign quot_src = quot_ff[j-1];
         assign den_src  = den_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      if (j == STAGES - 1) begin : g_last
         assign next_rdy = out_ready;
      end else begin : g_mid
         assign next_rdy = rdy[j+1];
      end

      assign rdy[j] = !v_ff[j] || next_rdy;

      always_comb begin
         logic [ntc_pkg::CMP_W-1:0] sh;
         rem_in  = rem_src;
         quot_in = quot_src;
         sh      = '0;
         for (int t = 0; t < STEPS_PER_STAGE; t++) begin
            if (K0 - t >= 0) begin
               sh = ntc_pkg::CMP_W'(den_src) << (K0 - t);
               if ({{PAD_W{1'b0}}, rem_in} >= sh) begin
                  rem_in  = rem_in - sh[ntc_pkg::NUM_W-1:0];
                  quot_in = quot_in | (ntc_pkg::QUOT_W'(1) << (K0 - t));
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j] && v_src) begin
            rem_ff[j]  <= rem_in;
            quot_ff[j] <= quot_in;
            den_ff[j]  <= den_src;
            side_ff[j] <= side_src;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_quot  = quot_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

// ----- verif/ntc_adc_to_temperature_core_tb.sv -----
// testbench for ntc_adc_to_temperature_core: directed and random adc samples with a
// bit-exact temperature predictor, random idling on both channels, csr setting phases
// depends on ntc_pkg and the core rtl only
`timescale 1ns / 1ps

module ntc_adc_to_temperature_core_tb;

   localparam int USED_ENTRIES =
      (ntc_pkg::TABLE_ENTRIES_DEFAULT > ntc_pkg::ROM_SIZE) ? ntc_pkg::ROM_SIZE :
      (ntc_pkg::TABLE_ENTRIES_DEFAULT < 2) ? 2 : ntc_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int PIPE_LATENCY =
      5 + (15 + ntc_pkg::DIV_STEPS_DEFAULT - 1) / ntc_pkg::DIV_STEPS_DEFAULT;
   localparam int MAX_GAP      = 17;
   localparam int LOW_EDGE_A   = 462;
   localparam int HIGH_EDGE_A  = 3003;
   localparam int SAMPLE_MAX   = 4095;
   localparam int TIMEOUT_NS   = 10_000_000;
   localparam logic [ntc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ntc_pkg::TEMP_W-1:0] temperature;
      logic                       sensor_fault;
   } temp_reading_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write = 1'b0;
   logic [ntc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ntc_pkg::CSR_DATA_W-1:0]  csr_data = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ntc_pkg::SAMPLE_W-1:0]    req_adc_sample = '0;
   logic                            req_channel_sel = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [ntc_pkg::TEMP_W-1:0]      rsp_temperature;
   logic                            rsp_sensor_fault;

   logic [ntc_pkg::OFFSET_W-1:0] offset_setting = ntc_pkg::ADC_OFFSET_RESET;
   logic [ntc_pkg::TRIM_W-1:0]   trim_zero_setting = ntc_pkg::TRIM_ZERO_RESET;
   logic [ntc_pkg::TRIM_W-1:0]   trim_one_setting = ntc_pkg::TRIM_ONE_RESET;

   temp_reading_type pending_readings[$];
   bit steady_flow = 1'b0;
   int sample_count = 0;
   int reading_count = 0;
   int fault_count = 0;
   int setting_count = 0;
   int mismatch_count = 0;

   ntc_adc_to_temperature_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_adc_sample   (req_adc_sample),
      .req_channel_sel  (req_channel_sel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_temperature  (rsp_temperature),
      .rsp_sensor_fault (rsp_sensor_fault)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [ntc_pkg::NUM_W-1:0] divider_ohms(
         input logic [ntc_pkg::A_W-1:0] a);
      logic [ntc_pkg::NUM_W-1:0] num;
      logic [ntc_pkg::NUM_W-1:0] den;
      num = ntc_pkg::NUM_W'(a) * ntc_pkg::DIV_SCALE;
      den = ntc_pkg::NUM_W'(ntc_pkg::FULL_SCALE - a);
      return num / den;
   endfunction

   function automatic temp_reading_type predict_reading(
         input logic [ntc_pkg::SAMPLE_W-1:0] sample, input logic chan);
      temp_reading_type           reading;
      logic [ntc_pkg::A_W-1:0]    a;
      logic [ntc_pkg::NUM_W-1:0]  ohms;
      logic [ntc_pkg::NUM_W-1:0]  hi;
      logic [ntc_pkg::NUM_W-1:0]  lo;
      logic [ntc_pkg::TRIM_W-1:0] trim;
      int                         idx;
      reading.temperature = '0;
      reading.sensor_fault = 1'b1;
      a = ntc_pkg::A_W'(sample) + ntc_pkg::A_W'(offset_setting);
      if (a >= ntc_pkg::FULL_SCALE) return reading;
      ohms = divider_ohms(a);
      if (ohms > ntc_pkg::NUM_W'(ntc_pkg::RES_ROM[0]) ||
          ohms < ntc_pkg::NUM_W'(ntc_pkg::RES_ROM[USED_ENTRIES-1])) return reading;
      idx = 0;
      for (int i = 0; i + 1 < USED_ENTRIES; i++) begin
         hi = ntc_pkg::NUM_W'(ntc_pkg::RES_ROM[i]);
         lo = ntc_pkg::NUM_W'(ntc_pkg::RES_ROM[i+1]);
         if (ohms <= hi && ohms >= lo) begin
            // nearer bracketing entry, ties go to the higher index
            if ((hi - ohms) < (ohms - lo)) idx = i;
            else idx = i + 1;
         end
      end
      trim = chan ? trim_one_setting : trim_zero_setting;
      reading.temperature = ntc_pkg::TEMP_W'(idx + int'(trim));
      reading.sensor_fault = 1'b0;
      return reading;
   endfunction

   // entered right after a rising edge; leaves valid high after the accepting edge
   task automatic send_sample(input logic [ntc_pkg::SAMPLE_W-1:0] sample, input logic chan);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= sample;
      req_channel_sel <= chan;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(predict_reading(sample, chan));
      sample_count++;
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ntc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ntc_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         ntc_pkg::CSR_ADC_OFFSET: offset_setting = data;
         ntc_pkg::CSR_TRIM_ZERO:  trim_zero_setting = data[ntc_pkg::TRIM_W-1:0];
         ntc_pkg::CSR_TRIM_ONE:   trim_one_setting = data[ntc_pkg::TRIM_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [ntc_pkg::OFFSET_W-1:0] offset,
                                input logic [ntc_pkg::TRIM_W-1:0] trim_zero,
                                input logic [ntc_pkg::TRIM_W-1:0] trim_one);
      wait_for_results;
      // upper data bits of the trim registers carry noise
      write_csr(ntc_pkg::CSR_ADC_OFFSET, offset);
      write_csr(ntc_pkg::CSR_TRIM_ZERO, {4'($urandom), trim_zero});
      write_csr(ntc_pkg::CSR_TRIM_ONE, {4'($urandom), trim_one});
      setting_count++;
   endtask

   task automatic test_default_settings;
      send_sample(12'd0, 1'b0);
      send_sample(12'(ntc_pkg::FULL_SCALE - 1 - ntc_pkg::ADC_OFFSET_RESET), 1'b1);
      send_sample(12'(ntc_pkg::FULL_SCALE - ntc_pkg::ADC_OFFSET_RESET), 1'b0);
      send_sample(12'(SAMPLE_MAX), 1'b1);
      send_sample(12'(2048 - ntc_pkg::ADC_OFFSET_RESET), 1'b0);
      send_sample(12'(2048 - ntc_pkg::ADC_OFFSET_RESET), 1'b1);
   endtask

   task automatic test_register_extremes;
      apply_setting(8'd0, 4'd15, 4'd15);
      send_sample(12'd0, 1'b0);
      send_sample(12'(SAMPLE_MAX), 1'b1);
      send_sample(12'(HIGH_EDGE_A), 1'b0);
      send_sample(12'(HIGH_EDGE_A + 1), 1'b1);
      send_sample(12'(LOW_EDGE_A - 1), 1'b0);
      send_sample(12'(LOW_EDGE_A), 1'b1);
      apply_setting(8'd255, 4'd8, 4'd0);
      send_sample(12'(SAMPLE_MAX), 1'b0);
      send_sample(12'd0, 1'b1);
      send_sample(12'(ntc_pkg::FULL_SCALE - 1 - 255), 1'b0);
   endtask

   task automatic test_table_points;
      logic [ntc_pkg::NUM_W-1:0] ohms;
      logic [ntc_pkg::NUM_W-1:0] hi;
      logic [ntc_pkg::NUM_W-1:0] lo;
      int exact_sample;
      int tie_sample;
      exact_sample = -1;
      tie_sample = -1;
      apply_setting(8'd0, 4'd8, 4'd1);
      // look for a sample landing on a rom entry and one exactly between two entries
      for (int a = 1; a <= SAMPLE_MAX; a++) begin
         ohms = divider_ohms(ntc_pkg::A_W'(a));
         for (int i = 1; i + 1 < USED_ENTRIES; i++) begin
            hi = ntc_pkg::NUM_W'(ntc_pkg::RES_ROM[i]);
            lo = ntc_pkg::NUM_W'(ntc_pkg::RES_ROM[i+1]);
            if (exact_sample < 0 && ohms == hi) exact_sample = a;
            if (tie_sample < 0 && ohms < hi && ohms > lo &&
                2 * ohms == int'(hi) + int'(lo)) tie_sample = a;
         end
      end
      if (exact_sample >= 0) begin
         send_sample(ntc_pkg::SAMPLE_W'(exact_sample), 1'b0);
         send_sample(ntc_pkg::SAMPLE_W'(exact_sample), 1'b1);
      end
      if (tie_sample >= 0) begin
         send_sample(ntc_pkg::SAMPLE_W'(tie_sample), 1'b0);
         send_sample(ntc_pkg::SAMPLE_W'(tie_sample), 1'b1);
      end
      // unused register index must leave every setting alone
      wait_for_results;
      write_csr(CSR_UNUSED, 8'hA5);
      send_sample(12'd2048, 1'b0);
      send_sample(12'd2048, 1'b1);
   endtask

   task automatic test_random_traffic(input int total);
      int per_phase;
      int pick;
      int cand;
      int flow_start;
      per_phase = total / 8;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_setting(8'd0, 4'd0, 4'd0);
            1: apply_setting(8'd255, 4'd15, 4'd15);
            2: apply_setting(ntc_pkg::ADC_OFFSET_RESET, 4'd8, 4'd8);
            default: apply_setting(8'($urandom), 4'($urandom_range(0, 8)),
                                   4'($urandom_range(0, 15)));
         endcase
         flow_start = $urandom_range(0, per_phase - 40);
         for (int n = 0; n < per_phase; n++) begin
            steady_flow = (n >= flow_start && n < flow_start + 30);
            if (n == per_phase / 2) wait_for_results;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               cand = int'($urandom_range(LOW_EDGE_A - 8, HIGH_EDGE_A + 8))
                      - int'(offset_setting);
            end else if (pick < 90) begin
               cand = $urandom_range(0, SAMPLE_MAX);
            end else begin
               case ($urandom_range(0, 5))
                  0: cand = 0;
                  1: cand = SAMPLE_MAX;
                  2: cand = int'(ntc_pkg::FULL_SCALE) - 1 - int'(offset_setting);
                  3: cand = int'(ntc_pkg::FULL_SCALE) - int'(offset_setting);
                  4: cand = LOW_EDGE_A - 1 - int'(offset_setting);
                  default: cand = HIGH_EDGE_A + 1 - int'(offset_setting);
               endcase
            end
            if (cand < 0 || cand > SAMPLE_MAX) cand = $urandom_range(0, SAMPLE_MAX);
            send_sample(ntc_pkg::SAMPLE_W'(cand), 1'($urandom));
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin : rsp_backpressure
      int hold;
      @(posedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      temp_reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: temperature %0d fault %0b",
                        rsp_temperature, rsp_sensor_fault);
         end else begin
            want = pending_readings.pop_front();
            reading_count++;
            if (rsp_sensor_fault) fault_count++;
            if (rsp_temperature !== want.temperature ||
                rsp_sensor_fault !== want.sensor_fault) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch on word %0d: expected temperature %0d fault %0b, got %0d %0b",
                           reading_count, want.temperature, want.sensor_fault,
                           rsp_temperature, rsp_sensor_fault);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d words outstanding", pending_readings.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_settings;
      test_register_extremes;
      test_table_points;
      test_random_traffic(1680);
      wait_for_results;
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      $display("checked %0d readings from %0d samples, %0d of them sensor faults",
               reading_count, sample_count, fault_count);
      $display("covered %0d register settings, %0d mismatches", setting_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
